[hw/rtl/dllce_pkg.sv]
// Package for the doubly linked list cursor engine.
// Holds the command codes, status codes, controller states and shared constants.
// No dependencies.
package dllce_pkg;

  localparam int POOL_DEPTH_DEF = 256;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [3:0] {
    OP_NOP        = 4'd0,
    OP_CLEAR      = 4'd1,
    OP_INS_FIRST  = 4'd2,
    OP_INS_LAST   = 4'd3,
    OP_INS_AFTER  = 4'd4,
    OP_INS_BEFORE = 4'd5,
    OP_DEL_FIRST  = 4'd6,
    OP_DEL_LAST   = 4'd7,
    OP_DEL_AFTER  = 4'd8,
    OP_DEL_BEFORE = 4'd9,
    OP_SET        = 4'd10,
    OP_FIRST      = 4'd11,
    OP_LAST       = 4'd12,
    OP_NEXT       = 4'd13,
    OP_PREV       = 4'd14
  } op_t;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_IGNORE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_FETCH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic read;
    logic exec;
    logic fetch;
    logic done;
  } ctrl_t;

endpackage

[hw/rtl/dllce_datapath.sv]
// Datapath of the list engine: node memories, pointers, free pool and result.
// Depends on dllce_pkg; sequenced by dllce_ctrl.
module dllce_datapath import dllce_pkg::*; #(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctrl_t              ctrl,
  input  logic [3:0]         in_operation,
  input  logic signed [31:0] in_value,
  output logic [1:0]         out_status,
  output logic               out_list_empty,
  output logic               out_cursor_valid,
  output logic signed [31:0] out_active_value,
  output logic signed [31:0] out_first_value,
  output logic signed [31:0] out_last_value,
  output logic [8:0]         out_node_count
);

  localparam int PW = $clog2(POOL_DEPTH + 1);
  localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam logic [PW-1:0] NIL = PW'(POOL_DEPTH);

  logic [DATA_WIDTH-1:0] dmem [POOL_DEPTH];
  logic [PW-1:0]         fmem [POOL_DEPTH];
  logic [PW-1:0]         bmem [POOL_DEPTH];

  logic [3:0]            op_r;
  logic [DATA_WIDTH-1:0] data_r;
  logic [PW-1:0] head_r, tail_r, cur_r, free_r, fresh_r, cnt_r;
  logic [PW-1:0] head_nxt, tail_nxt, cur_nxt, free_nxt, fresh_nxt, cnt_nxt;
  logic [1:0]    st_r, st_nxt;
  // Link reads of the cursor, head and tail nodes and of the free head.
  logic [PW-1:0] cf_r, cb_r, hf_r, tb_r, ff_r;
  // Link reads of the second-level neighbor for delete after and before.
  logic [PW-1:0] nf_r, nb_r;
  logic [DATA_WIDTH-1:0] av_r, fv_r, lv_r;

  // Up to four link writes and one data write per command.
  logic          fwe0, fwe1, bwe0, bwe1, dwe;
  logic [PW-1:0] fa0, fa1, ba0, ba1, da;
  logic [PW-1:0] fd0, fd1, bd0, bd1;
  logic [PW-1:0] newn;
  logic          have_node;

  function automatic logic ok(input logic [PW-1:0] p);
    return p < NIL;
  endfunction

  function automatic logic signed [31:0] sx(input logic [DATA_WIDTH-1:0] v);
    logic signed [63:0] w;
    w = 64'(signed'(v));
    return w[31:0];
  endfunction

  assign have_node = ok(free_r) || (fresh_r < NIL);
  assign newn      = ok(free_r) ? free_r : fresh_r;

  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      op_r   <= in_operation;
      data_r <= DATA_WIDTH'(64'(signed'(in_value)));
    end
    if (ctrl.read) begin
      cf_r <= ok(cur_r)  ? fmem[cur_r[AW-1:0]]  : NIL;
      cb_r <= ok(cur_r)  ? bmem[cur_r[AW-1:0]]  : NIL;
      hf_r <= ok(head_r) ? fmem[head_r[AW-1:0]] : NIL;
      tb_r <= ok(tail_r) ? bmem[tail_r[AW-1:0]] : NIL;
    end
    if (ctrl.fetch) begin
      nf_r <= ok(cf_r) ? fmem[cf_r[AW-1:0]] : NIL;
      nb_r <= ok(cb_r) ? bmem[cb_r[AW-1:0]] : NIL;
      ff_r <= ok(free_r) ? fmem[free_r[AW-1:0]] : NIL;
    end
    if (ctrl.done) begin
      av_r <= ok(cur_r) ? dmem[cur_r[AW-1:0]] : '0;
    end
    if (ctrl.exec) begin
      if (fwe0) fmem[fa0[AW-1:0]] <= fd0;
      if (fwe1) fmem[fa1[AW-1:0]] <= fd1;
      if (bwe0) bmem[ba0[AW-1:0]] <= bd0;
      if (bwe1) bmem[ba1[AW-1:0]] <= bd1;
      if (dwe)  dmem[da[AW-1:0]]  <= data_r;
      fv_r <= !ok(head_nxt) ? '0 :
              (dwe && da == head_nxt) ? data_r : dmem[head_nxt[AW-1:0]];
      lv_r <= !ok(tail_nxt) ? '0 :
              (dwe && da == tail_nxt) ? data_r : dmem[tail_nxt[AW-1:0]];
    end
  end

  always_comb begin
    head_nxt = head_r; tail_nxt = tail_r; cur_nxt = cur_r;
    free_nxt = free_r; fresh_nxt = fresh_r; cnt_nxt = cnt_r; st_nxt = ST_DONE;
    fwe0 = 1'b0; fwe1 = 1'b0; bwe0 = 1'b0; bwe1 = 1'b0; dwe = 1'b0;
    fa0 = newn; fa1 = newn; ba0 = newn; ba1 = newn; da = newn;
    fd0 = NIL; fd1 = NIL; bd0 = NIL; bd1 = NIL;
    case (op_r)
      OP_CLEAR: begin
        head_nxt = NIL; tail_nxt = NIL; cur_nxt = NIL; free_nxt = NIL;
        fresh_nxt = '0; cnt_nxt = '0;
      end
      OP_INS_FIRST, OP_INS_LAST, OP_INS_AFTER, OP_INS_BEFORE: begin
        if ((op_r == OP_INS_AFTER || op_r == OP_INS_BEFORE) && !ok(cur_r)) begin
          st_nxt = ST_IGNORE;
        end else if (!have_node) begin
          st_nxt = ST_FULL;
        end else begin
          if (ok(free_r)) free_nxt = ff_r;
          else fresh_nxt = fresh_r + 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          dwe = 1'b1; fwe0 = 1'b1; bwe0 = 1'b1;
          case (op_r)
            OP_INS_FIRST: begin
              fd0 = head_r;
              if (ok(head_r)) begin
                bwe1 = 1'b1; ba1 = head_r; bd1 = newn;
              end else tail_nxt = newn;
              head_nxt = newn;
            end
            OP_INS_LAST: begin
              bd0 = tail_r;
              if (ok(tail_r)) begin
                fwe1 = 1'b1; fa1 = tail_r; fd1 = newn;
              end else head_nxt = newn;
              tail_nxt = newn;
            end
            OP_INS_AFTER: begin
              fd0 = cf_r; bd0 = cur_r;
              fwe1 = 1'b1; fa1 = cur_r; fd1 = newn;
              if (ok(cf_r)) begin
                bwe1 = 1'b1; ba1 = cf_r; bd1 = newn;
              end else tail_nxt = newn;
            end
            default: begin
              bd0 = cb_r; fd0 = cur_r;
              bwe1 = 1'b1; ba1 = cur_r; bd1 = newn;
              if (ok(cb_r)) begin
                fwe1 = 1'b1; fa1 = cb_r; fd1 = newn;
              end else head_nxt = newn;
            end
          endcase
        end
      end
      OP_DEL_FIRST: begin
        if (!ok(head_r)) st_nxt = ST_IGNORE;
        else begin
          head_nxt = hf_r;
          if (ok(hf_r)) begin
            bwe0 = 1'b1; ba0 = hf_r; bd0 = NIL;
          end else tail_nxt = NIL;
          if (cur_r == head_r) cur_nxt = NIL;
          fwe1 = 1'b1; fa1 = head_r; fd1 = free_r; free_nxt = head_r;
          if (cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
        end
      end
      OP_DEL_LAST: begin
        if (!ok(tail_r)) st_nxt = ST_IGNORE;
        else begin
          tail_nxt = tb_r;
          if (ok(tb_r)) begin
            fwe0 = 1'b1; fa0 = tb_r; fd0 = NIL;
          end else head_nxt = NIL;
          if (cur_r == tail_r) cur_nxt = NIL;
          fwe1 = 1'b1; fa1 = tail_r; fd1 = free_r; free_nxt = tail_r;
          if (cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
        end
      end
      OP_DEL_AFTER: begin
        if (!ok(cur_r) || !ok(cf_r)) st_nxt = ST_IGNORE;
        else begin
          fwe0 = 1'b1; fa0 = cur_r; fd0 = nf_r;
          if (ok(nf_r)) begin
            bwe0 = 1'b1; ba0 = nf_r; bd0 = cur_r;
          end else tail_nxt = cur_r;
          fwe1 = 1'b1; fa1 = cf_r; fd1 = free_r; free_nxt = cf_r;
          if (cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
        end
      end
      OP_DEL_BEFORE: begin
        if (!ok(cur_r) || !ok(cb_r)) st_nxt = ST_IGNORE;
        else begin
          bwe0 = 1'b1; ba0 = cur_r; bd0 = nb_r;
          if (ok(nb_r)) begin
            fwe0 = 1'b1; fa0 = nb_r; fd0 = cur_r;
          end else head_nxt = cur_r;
          fwe1 = 1'b1; fa1 = cb_r; fd1 = free_r; free_nxt = cb_r;
          if (cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
        end
      end
      OP_SET: begin
        if (!ok(cur_r)) st_nxt = ST_IGNORE;
        else begin
          dwe = 1'b1; da = cur_r;
        end
      end
      OP_FIRST: cur_nxt = head_r;
      OP_LAST:  cur_nxt = tail_r;
      OP_NEXT: begin
        if (!ok(cur_r)) st_nxt = ST_IGNORE;
        else cur_nxt = cf_r;
      end
      OP_PREV: begin
        if (!ok(cur_r)) st_nxt = ST_IGNORE;
        else cur_nxt = cb_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= NIL; tail_r <= NIL; cur_r <= NIL; free_r <= NIL;
      fresh_r <= '0; cnt_r <= '0; st_r <= ST_DONE;
    end else if (ctrl.exec) begin
      head_r <= head_nxt; tail_r <= tail_nxt; cur_r <= cur_nxt; free_r <= free_nxt;
      fresh_r <= fresh_nxt; cnt_r <= cnt_nxt; st_r <= st_nxt;
    end
  end

  assign out_status       = st_r;
  assign out_list_empty   = !ok(head_r);
  assign out_cursor_valid = ok(cur_r);
  assign out_active_value = sx(av_r);
  assign out_first_value  = sx(fv_r);
  assign out_last_value   = sx(lv_r);
  assign out_node_count   = 9'(cnt_r);

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= PW'(POOL_DEPTH)) else $error("node count above pool depth");
  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    !ok(head_r) |-> (cnt_r == '0 && !ok(tail_r))) else $error("empty list inconsistent");
  a_cur_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !ok(head_r) |-> !ok(cur_r)) else $error("cursor set on empty list");

endmodule

[hw/rtl/dllce_ctrl.sv]
// Controller state machine of the list engine.
// Depends on dllce_pkg; drives dllce_datapath.
module dllce_ctrl import dllce_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  output logic  out_valid,
  output ctrl_t ctrl
);

  state_t state_r, state_nxt;

  always_comb begin
    case (state_r)
      S_IDLE:  state_nxt = start ? S_READ : S_IDLE;
      S_READ:  state_nxt = S_FETCH;
      S_FETCH: state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state_r)
      S_IDLE:  ctrl.latch = start;
      S_READ:  ctrl.read  = 1'b1;
      S_FETCH: ctrl.fetch = 1'b1;
      S_EXEC:  ctrl.exec  = 1'b1;
      S_DONE:  ctrl.done  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= ctrl.done;
  end

  assign busy = (state_r != S_IDLE);

  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctrl.latch, ctrl.read, ctrl.fetch, ctrl.exec, ctrl.done}))
    else $error("more than one step at once");
  a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.exec |=> ctrl.done) else $error("exec not followed by done");
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

endmodule

[hw/rtl/doubly_linked_list_cursor_engine_core.sv]
// Doubly linked list with cursor: one command accepted when start is high and busy low.
// out_valid is registered from the done step; busy holds through the read, fetch, exec
// and done states of the dependent link-memory read chain; commands do not overlap.
// The result strobe lasts one cycle and cannot be stalled.
// Synchronous active-low reset empties the list; no clearing pass is needed.
// Depends on dllce_pkg, dllce_ctrl and dllce_datapath.
module doubly_linked_list_cursor_engine_core import dllce_pkg::*; #(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         in_operation,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic               out_list_empty,
  output logic               out_cursor_valid,
  output logic signed [31:0] out_active_value,
  output logic signed [31:0] out_first_value,
  output logic signed [31:0] out_last_value,
  output logic [8:0]         out_node_count
);

  ctrl_t ctrl;

  dllce_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .out_valid(out_valid), .ctrl(ctrl)
  );

  dllce_datapath #(.POOL_DEPTH(POOL_DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl),
    .in_operation(in_operation), .in_value(in_value),
    .out_status(out_status), .out_list_empty(out_list_empty),
    .out_cursor_valid(out_cursor_valid), .out_active_value(out_active_value),
    .out_first_value(out_first_value), .out_last_value(out_last_value),
    .out_node_count(out_node_count)
  );

endmodule
